// ===== design/stmr_pkg.sv =====
// Shared types and constants for the serial transmit message ring.
// Used by stmr_front, stmr_back and serial_tx_message_ring; no dependencies.
package stmr_pkg;

  // Default ring size in bytes; one slot always stays free.
  localparam int unsigned RingDepthDefault = 64;

  // Command queue between front and back; must be a power of two.
  localparam int unsigned QueueDepth = 2;

  // Byte appended at end of message.
  localparam logic [7:0] NewlineByte = 8'h0A;

  // Input commands; the fourth code is ignored by the front.
  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdEnd    = 2'd1,
    CmdTxDone = 2'd2
  } cmd_e;

  // One queued command.
  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } q_entry_t;

  // Status of the back end, seen at the top level.
  typedef struct packed {
    logic busy;
    logic fetching;
  } back_status_t;

endpackage

// ===== design/serial_tx_message_ring.sv =====
// Serial transmit message ring: bytes are queued into a RING_DEPTH-byte ring
// (one slot kept free) and published a message at a time; an end-of-message
// word appends a newline, publishes, and starts the transmitter if idle; a
// transmit-complete word hands out the next published byte. A two-word
// command queue sits between the input and the ring engine. In the engine an
// append or a word that sends nothing ends in the execute state; a word that
// sends a byte goes through execute, registered ring read and result load,
// set by the single registered read port of the ring. A waiting result
// stalls the engine, not the input, until the queue fills. The ring needs no
// clearing after reset. Depends on stmr_pkg, stmr_front and stmr_back.
module serial_tx_message_ring #(
  parameter int unsigned RING_DEPTH = stmr_pkg::RingDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       overflow_o
);
  import stmr_pkg::*;

  logic         q_valid, q_ready;
  q_entry_t     q_entry;
  back_status_t status;

  // Accept and classify input words.
  stmr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_entry_o   (q_entry)
  );

  // Execute commands on the ring.
  stmr_back #(
    .RingDepth (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .overflow_o  (overflow_o),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  // A sent byte always leaves the transmitter marked busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o |-> status.busy)
    else $error("byte result while transmitter idle");

  // A ring read always turns into a result, through the load state into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fetching |-> ##2 out_valid_o)
    else $error("ring read did not produce a result");

  // The input stalls only when the queue holds work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with empty queue");
`endif

endmodule

// ===== design/stmr_front.sv =====
// Front end of the serial transmit message ring: accepts input words,
// drops unused command codes and queues the rest. Depends on stmr_pkg.
module stmr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          data_byte_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output stmr_pkg::q_entry_t  q_entry_o
);
  import stmr_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW:0] FullCount = (PtrW + 1)'(QueueDepth);

  q_entry_t        entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            push, pop, known_cmd;

  // Classify: only the three defined commands enter the queue.
  assign known_cmd = (command_i == CmdAppend) || (command_i == CmdEnd) ||
                     (command_i == CmdTxDone);

  assign in_ready_o = (count_q != FullCount);
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entry_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o && known_cmd;
  assign pop  = q_valid_o && q_ready_i;

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store queued words; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: cmd_e'(command_i), data: data_byte_i};
    end
  end

endmodule

// ===== design/stmr_back.sv =====
// Back end of the serial transmit message ring: executes queued commands
// on the ring memory and drives the result register. Depends on stmr_pkg.
module stmr_back #(
  parameter int unsigned RingDepth = stmr_pkg::RingDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  stmr_pkg::q_entry_t     q_entry_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             tx_byte_o,
  output logic                   overflow_o,
  output stmr_pkg::back_status_t status_o
);
  import stmr_pkg::*;

  localparam int unsigned PosW = $clog2(RingDepth);
  localparam logic [PosW-1:0] LastPos = PosW'(RingDepth - 1);

  typedef enum logic [1:0] {
    StExec,
    StFetch,
    StLoad
  } state_e;

  state_e         state_q;
  logic [7:0]     ring_q [RingDepth];
  logic [7:0]     rd_data_q;
  logic [PosW-1:0] wr_pos_q, commit_pos_q, rd_pos_q;
  logic [PosW-1:0] wr_pos_inc, rd_pos_inc, wr_pos_end;
  logic           busy_q, ovf_pend_q;
  logic           out_valid_q, overflow_q;
  logic [7:0]     tx_byte_q;
  logic           take, ring_full;
  logic           mem_we;
  logic [7:0]     mem_wdata;

  // Wrap positions at the ring end.
  assign wr_pos_inc = (wr_pos_q == LastPos) ? '0 : wr_pos_q + 1'b1;
  assign rd_pos_inc = (rd_pos_q == LastPos) ? '0 : rd_pos_q + 1'b1;
  assign ring_full  = (wr_pos_inc == rd_pos_q);
  assign wr_pos_end = ring_full ? wr_pos_q : wr_pos_inc;

  // Take a command only in the execute state with the result slot free.
  assign q_ready_o = (state_q == StExec) && !out_valid_q;
  assign take      = q_valid_i && q_ready_o;

  // Ring write: a data byte or the end-of-message newline.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = q_entry_i.data;
    if (take && !ring_full) begin
      case (q_entry_i.op)
        CmdAppend: mem_we = 1'b1;
        CmdEnd: begin
          mem_we    = 1'b1;
          mem_wdata = NewlineByte;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wr_pos_q] <= mem_wdata;
    end
    if (state_q == StFetch) begin
      rd_data_q <= ring_q[rd_pos_q];
    end
  end

  // Sequencer, ring positions and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StExec;
      wr_pos_q     <= '0;
      commit_pos_q <= '0;
      rd_pos_q     <= '0;
      busy_q       <= 1'b0;
      ovf_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      overflow_q   <= 1'b0;
      tx_byte_q    <= '0;
    end else begin
      // Drop the result once taken.
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StExec: begin
          if (take) begin
            case (q_entry_i.op)
              CmdAppend: begin
                if (ring_full) begin
                  out_valid_q <= 1'b1;
                  overflow_q  <= 1'b1;
                  tx_byte_q   <= '0;
                end else begin
                  wr_pos_q <= wr_pos_inc;
                end
              end
              CmdEnd: begin
                wr_pos_q     <= wr_pos_end;
                commit_pos_q <= wr_pos_end;
                if (!busy_q && (rd_pos_q != wr_pos_end)) begin
                  busy_q     <= 1'b1;
                  ovf_pend_q <= ring_full;
                  state_q    <= StFetch;
                end else if (ring_full) begin
                  out_valid_q <= 1'b1;
                  overflow_q  <= 1'b1;
                  tx_byte_q   <= '0;
                end
              end
              CmdTxDone: begin
                if (rd_pos_q != commit_pos_q) begin
                  busy_q     <= 1'b1;
                  ovf_pend_q <= 1'b0;
                  state_q    <= StFetch;
                end else begin
                  busy_q <= 1'b0;
                end
              end
              default: state_q <= StExec;
            endcase
          end
        end
        StFetch: begin
          rd_pos_q <= rd_pos_inc;
          state_q  <= StLoad;
        end
        StLoad: begin
          out_valid_q <= 1'b1;
          tx_byte_q   <= rd_data_q;
          overflow_q  <= ovf_pend_q;
          state_q     <= StExec;
        end
        default: state_q <= StExec;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign overflow_o  = overflow_q;
  assign status_o    = '{busy: busy_q, fetching: (state_q == StFetch)};

endmodule
